// File: rtl/prls_pkg.sv
// Package for the position range limit select block.
// Holds the shared types, sizes and codes; no dependencies.
package prls_pkg;

    // Fixed sizes of the interface fields.
    localparam int NUM_RANGES = 4;
    localparam int POS_WIDTH  = 32;
    localparam int IDX_W      = 2;
    localparam int MASK_W     = 4;

    // Command action codes.
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_WRITE  = 1'b1;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_DEFAULT_LOW  = 1'b0,
        CFG_DEFAULT_HIGH = 1'b1
    } t_cfg_reg;

    typedef logic signed [POS_WIDTH-1:0] t_pos;

    // One input command.
    typedef struct packed {
        logic             action;
        t_pos             feedback;
        logic [IDX_W-1:0] entry_index;
        t_pos             range_low;
        t_pos             range_high;
        t_pos             limit_low;
        t_pos             limit_high;
        logic             entry_enable;
        logic             entry_sticky;
    } t_cmd;

    // One result.
    typedef struct packed {
        t_pos              limit_min;
        t_pos              limit_max;
        logic [IDX_W-1:0]  selected_range;
        logic              def_limit_fault;
        logic              no_match_fault;
        logic [MASK_W-1:0] range_error_mask;
        logic [MASK_W-1:0] limit_error_mask;
    } t_result;

    // One range table entry as stored in memory.
    typedef struct packed {
        t_pos range_low;
        t_pos range_high;
        t_pos limit_low;
        t_pos limit_high;
    } t_entry;

    // Table write request.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] index;
        t_entry           entry;
        logic             enable;
        logic             sticky;
    } t_tbl_wr;

    // Sample sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STICKY,
        ST_SEARCH,
        ST_REPORT
    } t_state;

endpackage

// File: rtl/prls_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module prls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/prls_table.sv
// Range table: entry memory with per-entry valid bits, plus enable and sticky bits.
// Depends on prls_pkg and prls_ram.
module prls_table
    import prls_pkg::*;
#(
    parameter int NUM_RANGES = prls_pkg::NUM_RANGES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_tbl_wr                 i_wr,
    input  logic                    i_rd_en,
    input  logic [(NUM_RANGES > 1 ? $clog2(NUM_RANGES) : 1)-1:0] i_rd_addr,
    output t_entry                  o_rd_entry,
    output logic [NUM_RANGES-1:0]   o_enable,
    output logic [NUM_RANGES-1:0]   o_sticky
);

    localparam int ADDR_W = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;

    logic                  wr_ok;
    logic [ADDR_W-1:0]     wr_addr;
    logic [$bits(t_entry)-1:0] ram_q;
    logic [NUM_RANGES-1:0] r_valid;
    logic [NUM_RANGES-1:0] r_enable;
    logic [NUM_RANGES-1:0] r_sticky;
    logic                  r_rd_valid;

    // Writes to an index past the table are dropped.
    assign wr_ok   = i_wr.en && (int'(i_wr.index) < NUM_RANGES);
    assign wr_addr = i_wr.index[ADDR_W-1:0];

    prls_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (NUM_RANGES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_ok),
        .i_waddr (wr_addr),
        .i_wdata (i_wr.entry),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (ram_q)
    );

    // Valid, enable and sticky bits; an entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_enable   <= '1;
            r_sticky   <= '1;
            r_rd_valid <= 1'b0;
        end else begin
            if (wr_ok) begin
                r_valid[wr_addr]  <= 1'b1;
                r_enable[wr_addr] <= i_wr.enable;
                r_sticky[wr_addr] <= i_wr.sticky;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_entry = r_rd_valid ? t_entry'(ram_q) : '0;
    assign o_enable   = r_enable;
    assign o_sticky   = r_sticky;

endmodule

// File: rtl/prls_ctrl.sv
// Sample sequencer: sticky check, table walk and the held limits and error flags.
// Depends on prls_pkg; reads the table through prls_table.
module prls_ctrl
    import prls_pkg::*;
#(
    parameter int NUM_RANGES = prls_pkg::NUM_RANGES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_sample,
    input  t_pos                  i_feedback,
    input  t_pos                  i_def_low,
    input  t_pos                  i_def_high,
    input  t_entry                i_rd_entry,
    input  logic [NUM_RANGES-1:0] i_enable,
    input  logic [NUM_RANGES-1:0] i_sticky,
    output logic                  o_rd_en,
    output logic [(NUM_RANGES > 1 ? $clog2(NUM_RANGES) : 1)-1:0] o_rd_addr,
    output logic                  o_busy,
    output logic                  o_done,
    output t_result               o_result
);

    localparam int ADDR_W = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NUM_RANGES - 1);

    t_state                r_state, n_state;
    t_pos                  r_fb, n_fb;
    logic [ADDR_W-1:0]     r_idx, n_idx;
    logic [IDX_W-1:0]      r_cur, n_cur;
    t_pos                  r_out_low, n_out_low;
    t_pos                  r_out_high, n_out_high;
    logic                  r_err_def, n_err_def;
    logic                  r_err_nr, n_err_nr;
    logic [NUM_RANGES-1:0] r_rerr, n_rerr;
    logic [NUM_RANGES-1:0] r_lerr, n_lerr;

    logic def_inv;
    logic fb_in;
    logic rng_inv;
    logic lim_inv;
    logic sticky_hit;
    logic found;
    logic last;

    // Comparisons on the entry that the memory returned this cycle.
    assign def_inv    = i_def_high < i_def_low;
    assign fb_in      = (r_fb >= i_rd_entry.range_low) && (r_fb <= i_rd_entry.range_high);
    assign rng_inv    = i_rd_entry.range_high < i_rd_entry.range_low;
    assign lim_inv    = i_rd_entry.limit_high < i_rd_entry.limit_low;
    assign sticky_hit = i_sticky[r_cur[ADDR_W-1:0]] && i_enable[r_cur[ADDR_W-1:0]] && fb_in;
    assign found      = i_enable[r_idx] && !rng_inv && !lim_inv && fb_in;
    assign last       = (r_idx == LAST_IDX);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_sample) begin
                    n_state = ST_STICKY;
                end
            end
            ST_STICKY: begin
                n_state = (def_inv || sticky_hit) ? ST_REPORT : ST_SEARCH;
            end
            ST_SEARCH: begin
                if (found || last) begin
                    n_state = ST_REPORT;
                end
            end
            ST_REPORT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Next values of the held limits, index and error flags.
    always_comb begin
        n_fb       = r_fb;
        n_idx      = r_idx;
        n_cur      = r_cur;
        n_out_low  = r_out_low;
        n_out_high = r_out_high;
        n_err_def  = r_err_def;
        n_err_nr   = r_err_nr;
        n_rerr     = r_rerr;
        n_lerr     = r_lerr;
        case (r_state)
            ST_IDLE: begin
                if (i_sample) begin
                    n_fb = i_feedback;
                end
            end
            ST_STICKY: begin
                n_err_def = def_inv;
                n_idx     = '0;
                if (!def_inv && sticky_hit) begin
                    n_out_low  = i_rd_entry.limit_low;
                    n_out_high = i_rd_entry.limit_high;
                end
            end
            ST_SEARCH: begin
                n_idx = r_idx + ADDR_W'(1);
                if (i_enable[r_idx]) begin
                    n_rerr[r_idx] = rng_inv;
                    if (!rng_inv) begin
                        n_lerr[r_idx] = lim_inv;
                    end
                end
                if (found) begin
                    n_out_low  = i_rd_entry.limit_low;
                    n_out_high = i_rd_entry.limit_high;
                    n_err_nr   = 1'b0;
                    n_cur      = IDX_W'(r_idx);
                end else if (last) begin
                    n_err_nr = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Table reads and handshake outputs.
    always_comb begin
        o_rd_en   = 1'b0;
        o_rd_addr = r_cur[ADDR_W-1:0];
        case (r_state)
            ST_IDLE: begin
                o_rd_en   = i_sample;
                o_rd_addr = r_cur[ADDR_W-1:0];
            end
            ST_STICKY: begin
                o_rd_en   = !(def_inv || sticky_hit);
                o_rd_addr = '0;
            end
            ST_SEARCH: begin
                o_rd_en   = !(found || last);
                o_rd_addr = r_idx + ADDR_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_REPORT);

    // Result is taken straight from the held state.
    always_comb begin
        o_result.limit_min        = r_out_low;
        o_result.limit_max        = r_out_high;
        o_result.selected_range   = r_cur;
        o_result.def_limit_fault  = r_err_def;
        o_result.no_match_fault   = r_err_nr;
        o_result.range_error_mask = MASK_W'(r_rerr);
        o_result.limit_error_mask = MASK_W'(r_lerr);
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cur      <= '0;
            r_out_low  <= '0;
            r_out_high <= '0;
            r_err_def  <= 1'b0;
            r_err_nr   <= 1'b0;
            r_rerr     <= '0;
            r_lerr     <= '0;
        end else begin
            r_state    <= n_state;
            r_cur      <= n_cur;
            r_out_low  <= n_out_low;
            r_out_high <= n_out_high;
            r_err_def  <= n_err_def;
            r_err_nr   <= n_err_nr;
            r_rerr     <= n_rerr;
            r_lerr     <= n_lerr;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_fb  <= n_fb;
        r_idx <= n_idx;
    end

endmodule

// File: rtl/position_range_limit_select.sv
// Top level of the position range limit select block.
// Depends on prls_pkg, prls_table and prls_ctrl.
//
// Usage:
// A command is transferred when start is high and busy is low. A write command
// (action = write) loads one range table entry in that cycle and leaves busy low,
// so the next command can follow at once; it gives no result.
// A sample command raises busy, checks the default limits and the current sticky
// entry, and otherwise walks the table one entry per cycle through the single
// read port of the entry memory. Its result is shown on o_result for exactly one
// cycle with o_done high; the receiver cannot hold it off.
// A sample ends after the sticky check when the defaults are inverted or the
// sticky entry still holds the feedback, else when the walk finds a match or
// reaches the last entry. The result strobe comes in the last busy cycle; busy
// falls after it. The configuration channel is always ready; it is to be written
// by the user only while idle, since the block itself does not enforce that.
// Reset clears the defaults, limits, index and flags, marks every entry empty
// (reads as zero) and sets all enable and sticky bits; no clearing pass runs.
// NUM_RANGES may range from 1 to 4.
module position_range_limit_select
    import prls_pkg::*;
#(
    parameter int NUM_RANGES = prls_pkg::NUM_RANGES
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_cmd     i_cmd,
    output logic     o_done,
    output t_result  o_result,
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  logic [0:0] i_cfg_index,
    input  t_pos     i_cfg_data
);

    localparam int ADDR_W = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;

    t_pos                  r_def_low;
    t_pos                  r_def_high;
    logic                  cmd_xfer;
    logic                  sample_xfer;
    t_tbl_wr               tbl_wr;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    t_entry                rd_entry;
    logic [NUM_RANGES-1:0] ent_enable;
    logic [NUM_RANGES-1:0] ent_sticky;

    // Command transfers.
    assign cmd_xfer    = start && !busy;
    assign sample_xfer = cmd_xfer && (i_cmd.action == ACT_SAMPLE);

    // Table write request from a write command.
    always_comb begin
        tbl_wr.en               = cmd_xfer && (i_cmd.action == ACT_WRITE);
        tbl_wr.index            = i_cmd.entry_index;
        tbl_wr.entry.range_low  = i_cmd.range_low;
        tbl_wr.entry.range_high = i_cmd.range_high;
        tbl_wr.entry.limit_low  = i_cmd.limit_low;
        tbl_wr.entry.limit_high = i_cmd.limit_high;
        tbl_wr.enable           = i_cmd.entry_enable;
        tbl_wr.sticky           = i_cmd.entry_sticky;
    end

    // Default limit registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_low  <= '0;
            r_def_high <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DEFAULT_LOW:  r_def_low  <= i_cfg_data;
                CFG_DEFAULT_HIGH: r_def_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    prls_table #(
        .NUM_RANGES (NUM_RANGES)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (tbl_wr),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_entry (rd_entry),
        .o_enable   (ent_enable),
        .o_sticky   (ent_sticky)
    );

    prls_ctrl #(
        .NUM_RANGES (NUM_RANGES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (sample_xfer),
        .i_feedback (i_cmd.feedback),
        .i_def_low  (r_def_low),
        .i_def_high (r_def_high),
        .i_rd_entry (rd_entry),
        .i_enable   (ent_enable),
        .i_sticky   (ent_sticky),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_busy     (busy),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    // A sample transfer always starts a sequence.
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sample_xfer |=> busy)
        else $error("sample transfer did not raise busy");

    // A write transfer never occupies the sequencer.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_wr.en |=> !busy && !o_done)
        else $error("write transfer started a sequence");

    // The result strobe ends the sequence.
    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy && !o_done)
        else $error("busy held after result strobe");

    // The selected range always names an existing entry.
    a_sel_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (int'(o_result.selected_range) < NUM_RANGES))
        else $error("selected range out of table");

endmodule
